### hw/rtl/utf8_byte_sanitizer_macros.svh
// Assertion macros for the UTF-8 byte sanitizer checkers.
`ifndef UTF8_BYTE_SANITIZER_MACROS_SVH
`define UTF8_BYTE_SANITIZER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define UBS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define UBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/ubs_pkg.sv
// Shared types and constants for the UTF-8 byte sanitizer.
package ubs_pkg;

	localparam int QueueDepthDefault = 4;

	localparam logic [7:0] SpaceByte    = 8'h20;
	localparam logic [7:0] CrByte       = 8'h0D;
	localparam logic [7:0] LfByte       = 8'h0A;
	localparam logic [7:0] AsciiTop     = 8'h80;
	localparam logic [7:0] Lead2Min     = 8'hC2;
	localparam logic [7:0] Lead3Min     = 8'hE0;
	localparam logic [7:0] Lead4Min     = 8'hF0;
	localparam logic [15:0] SurrLo      = 16'hD800;
	localparam logic [15:0] SurrHi      = 16'hDFFF;
	localparam logic [15:0] Min3Byte    = 16'h0800;
	localparam logic [15:0] NoncharLo   = 16'hFFF0;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_stream;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       was_replaced;
		logic       run_last;
	} out_word_t;

	typedef struct packed {
		logic [1:0]      cnt;
		logic [2:0][7:0] bytes;
		logic [2:0]      repl;
	} ubs_bundle_t;

	typedef struct packed {
		logic        valid;
		ubs_bundle_t bundle;
	} ubs_entry_t;

endpackage

### hw/rtl/ubs_front.sv
// Front end: takes input words, tracks held sequences and builds result bundles.
module ubs_front import ubs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic       cfg_data,
	input  logic       accept,
	input  in_word_t   in_word,
	output ubs_entry_t push
);

	logic       fixup_q;
	logic [1:0] held_cnt_q;
	logic [7:0] held0_q, held1_q;

	logic [7:0]  b;
	logic        fresh_ctrl, fresh_bad, fresh_lead, is_cont, need3, seq_bad;
	logic [15:0] val;
	logic        emit_held, held_repl, emit_new, new_repl;
	logic [1:0]  nxt_cnt;
	logic [7:0]  nxt0, nxt1;
	logic [1:0]  cnt;

	always_comb begin
		b          = in_word.in_byte;
		fresh_ctrl = (b < SpaceByte) && (b != CrByte) && (b != LfByte);
		fresh_bad  = fresh_ctrl || ((b >= AsciiTop) && ((b < Lead2Min) || (b >= Lead4Min)));
		fresh_lead = (b >= Lead2Min) && (b < Lead4Min);
		is_cont    = (b[7:6] == 2'b10);
		need3      = (held0_q >= Lead3Min);
		val        = need3 ? {held0_q[3:0], held1_q[5:0], b[5:0]}
		                   : {5'd0, held0_q[4:0], b[5:0]};
		seq_bad    = ((val >= SurrLo) && (val <= SurrHi)) || (need3 && (val < Min3Byte))
		          || (val >= NoncharLo);

		emit_held = 1'b0;
		held_repl = 1'b0;
		emit_new  = 1'b0;
		new_repl  = 1'b0;
		nxt_cnt   = held_cnt_q;
		nxt0      = held0_q;
		nxt1      = held1_q;

		priority if (!fixup_q) begin
			emit_held = 1'b1;
			emit_new  = 1'b1;
			nxt_cnt   = 2'd0;
		end else if (held_cnt_q == 2'd0) begin
			if (fresh_lead) begin
				nxt0    = b;
				nxt_cnt = 2'd1;
			end else begin
				emit_new = 1'b1;
				new_repl = fresh_bad;
			end
		end else if (is_cont) begin
			if (need3 && (held_cnt_q == 2'd1)) begin
				nxt1    = b;
				nxt_cnt = 2'd2;
			end else begin
				emit_held = 1'b1;
				held_repl = seq_bad;
				emit_new  = 1'b1;
				new_repl  = seq_bad;
				nxt_cnt   = 2'd0;
			end
		end else begin
			emit_held = 1'b1;
			held_repl = 1'b1;
			if (fresh_lead) begin
				nxt0    = b;
				nxt_cnt = 2'd1;
			end else begin
				emit_new = 1'b1;
				new_repl = fresh_bad;
				nxt_cnt  = 2'd0;
			end
		end

		if (in_word.end_of_stream) begin
			nxt_cnt = 2'd0;
		end

		cnt = (emit_held ? held_cnt_q : 2'd0) + {1'b0, emit_new};

		push.valid              = accept && (cnt != 2'd0);
		push.bundle.cnt         = cnt;
		push.bundle.bytes[0]    = (held_cnt_q == 2'd0) ? b : held0_q;
		push.bundle.bytes[1]    = (held_cnt_q == 2'd2) ? held1_q : b;
		push.bundle.bytes[2]    = b;
		push.bundle.repl[0]     = (held_cnt_q == 2'd0) ? new_repl : held_repl;
		push.bundle.repl[1]     = (held_cnt_q == 2'd2) ? held_repl : new_repl;
		push.bundle.repl[2]     = new_repl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixup_q    <= 1'b0;
			held_cnt_q <= 2'd0;
		end else begin
			if (cfg_valid) begin
				fixup_q <= cfg_data;
			end
			if (accept) begin
				held_cnt_q <= nxt_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held0_q <= nxt0;
			held1_q <= nxt1;
		end
	end

endmodule

### hw/rtl/ubs_queue.sv
// Bundle queue between front and back ends.
module ubs_queue import ubs_pkg::*; #(
	parameter int QueueDepth = QueueDepthDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ubs_entry_t push,
	input  logic       pop,
	output logic       full,
	output ubs_entry_t head
);

	localparam int AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CW = $clog2(QueueDepth + 1);

	ubs_bundle_t   mem_q [QueueDepth];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full        = (count_q == CW'(QueueDepth));
	assign head.valid  = (count_q != '0);
	assign head.bundle = mem_q[rd_q];
	assign do_push     = push.valid && !full;
	assign do_pop      = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push.bundle;
		end
	end

endmodule

### hw/rtl/ubs_back.sv
// Back end: serializes queued bundles into output words.
module ubs_back import ubs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ubs_entry_t head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output out_word_t  out_word
);

	logic       out_valid_q;
	out_word_t  out_word_q;
	logic [1:0] idx_q;
	logic       load, last;
	logic [7:0] sel_byte;
	logic       sel_repl;

	always_comb begin
		unique case (idx_q)
			2'd0: begin
				sel_byte = head.bundle.bytes[0];
				sel_repl = head.bundle.repl[0];
			end
			2'd1: begin
				sel_byte = head.bundle.bytes[1];
				sel_repl = head.bundle.repl[1];
			end
			default: begin
				sel_byte = head.bundle.bytes[2];
				sel_repl = head.bundle.repl[2];
			end
		endcase
	end

	assign load      = head.valid && (!out_valid_q || !out_stall);
	assign last      = (idx_q == (head.bundle.cnt - 2'd1));
	assign pop       = load && last;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_word_q.out_byte     <= sel_repl ? SpaceByte : sel_byte;
			out_word_q.was_replaced <= sel_repl;
			out_word_q.run_last     <= last;
		end
	end

endmodule

### hw/rtl/utf8_byte_sanitizer.sv
// Top level of the UTF-8 byte sanitizer.
// Path: when an input word is taken, its results are written into the bundle queue as
// one bundle, and the back end registers them one by one from the queue head.
// Throughput: one input word per cycle unless in_stall; one output word per cycle
// unless out_stall, so an input with two or three results holds the output side
// until all are sent. The bundle queue (QueueDepth entries) absorbs those bursts.
// Reset: asynchronous, clears held-sequence count, queue, output valid and fixup_q.
module utf8_byte_sanitizer import ubs_pkg::*; #(
	parameter int QueueDepth = QueueDepthDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	ubs_entry_t push, head;
	logic       full, pop, accept;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;
	assign accept    = in_valid && !full;

	ubs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.in_word   (in_word),
		.push      (push)
	);

	ubs_queue #(
		.QueueDepth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (full),
		.head   (head)
	);

	ubs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

### hw/rtl/ubs_checker.sv
// Port-level checker for the UTF-8 byte sanitizer, bound to the top level.
`include "utf8_byte_sanitizer_macros.svh"

module ubs_checker import ubs_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_word_t out_word
);

	`UBS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled output word changed")
	`UBS_ASSERT_NOW(a_repl_space, out_valid && out_word.was_replaced, out_word.out_byte == SpaceByte, "replaced word is not a space")
	`UBS_ASSERT_NEXT(a_run_cont, out_valid && !out_stall && !out_word.run_last, out_valid, "gap inside a result run")

endmodule

bind utf8_byte_sanitizer ubs_checker u_ubs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);

### tb/utf8_byte_sanitizer_tb.sv
// Self-checking testbench for the UTF-8 byte sanitizer: directed and random byte streams.
`timescale 1ns / 100ps

module utf8_byte_sanitizer_tb import ubs_pkg::*;;

	logic      clk;
	logic      arst_n;
	logic      cfg_valid;
	logic      cfg_ready;
	logic      cfg_data;
	logic      in_valid;
	logic      in_stall;
	in_word_t  in_word;
	logic      out_valid;
	logic      out_stall;
	out_word_t out_word;

	logic       fixup_on;
	logic [1:0] held_cnt;
	logic [7:0] held_bytes [2];
	out_word_t  expected_words [$];

	int unsigned send_idle_pct;
	int unsigned stall_pct;
	int          errors;
	int          words_sent;
	int          words_checked;
	int          spaces_checked;

	utf8_byte_sanitizer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("Timeout at %0t with %0d words still expected", $time, expected_words.size());
		$display("*** FAILED ***");
		$finish;
	end

	function automatic void push_word(input logic [7:0] b, input logic replaced);
		out_word_t w;
		w.out_byte     = replaced ? SpaceByte : b;
		w.was_replaced = replaced;
		w.run_last     = 1'b0;
		expected_words.push_back(w);
	endfunction

	function automatic void take_fresh(input logic [7:0] b);
		if (b < SpaceByte && b != CrByte && b != LfByte) begin
			push_word(b, 1'b1);
		end else if (b < AsciiTop) begin
			push_word(b, 1'b0);
		end else if (b < Lead2Min || b >= Lead4Min) begin
			push_word(b, 1'b1);
		end else begin
			held_bytes[0] = b;
			held_cnt      = 2'd1;
		end
	endfunction

	function automatic void predict_sanitized(input logic [7:0] b, input logic eos);
		int         n0;
		int         need;
		logic [15:0] code;
		logic        bad;
		out_word_t   last;
		n0 = expected_words.size();
		if (!fixup_on) begin
			for (int i = 0; i < held_cnt; i++)
				push_word(held_bytes[i % 2], 1'b0);
			held_cnt = 2'd0;
			push_word(b, 1'b0);
		end else if (held_cnt == 2'd0) begin
			take_fresh(b);
		end else if (b[7:6] == 2'b10) begin
			need = (held_bytes[0] >= Lead3Min) ? 3 : 2;
			if (held_cnt + 1 < need) begin
				held_bytes[held_cnt[0]] = b;
				held_cnt = held_cnt + 2'd1;
			end else begin
				if (need == 2)
					code = {5'd0, held_bytes[0][4:0], b[5:0]};
				else
					code = {held_bytes[0][3:0], held_bytes[1][5:0], b[5:0]};
				bad = (code >= SurrLo && code <= SurrHi) || (need == 3 && code < Min3Byte)
					|| code >= NoncharLo;
				for (int i = 0; i + 1 < need; i++)
					push_word(held_bytes[i % 2], bad);
				push_word(b, bad);
				held_cnt = 2'd0;
			end
		end else begin
			for (int i = 0; i < held_cnt; i++)
				push_word(held_bytes[i % 2], 1'b1);
			held_cnt = 2'd0;
			take_fresh(b);
		end
		if (eos)
			held_cnt = 2'd0;
		if (expected_words.size() > n0) begin
			last = expected_words.pop_back();
			last.run_last = 1'b1;
			expected_words.push_back(last);
		end
	endfunction

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : check_words
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$display("%0t: expected no word, got %h/%b/%b (byte/replaced/last)",
					$time, out_word.out_byte, out_word.was_replaced, out_word.run_last);
				errors++;
			end else begin
				want = expected_words.pop_front();
				if (out_word.out_byte !== want.out_byte
						|| out_word.was_replaced !== want.was_replaced
						|| out_word.run_last !== want.run_last) begin
					$display("%0t: expected %h/%b/%b, got %h/%b/%b (byte/replaced/last)",
						$time, want.out_byte, want.was_replaced, want.run_last,
						out_word.out_byte, out_word.was_replaced, out_word.run_last);
					errors++;
				end
				words_checked++;
				if (want.was_replaced)
					spaces_checked++;
			end
		end
	end

	task automatic send_word(input logic [7:0] b, input logic eos);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= '{in_byte: b, end_of_stream: eos};
		do @(posedge clk); while (in_stall);
		predict_sanitized(b, eos);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic set_fixup(input logic v);
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		fixup_on = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_single_bytes();
		send_word(8'h00, 1'b0);
		send_word(8'h0A, 1'b0);
		send_word(8'h0D, 1'b0);
		send_word(8'h7F, 1'b0);
		send_word(8'hC1, 1'b0);
		send_word(8'hFF, 1'b0);
	endtask

	task automatic test_multibyte_codes();
		send_word(8'hC2, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'hE0, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'hED, 1'b0);
		send_word(8'hA0, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'hEF, 1'b0);
		send_word(8'hBF, 1'b0);
		send_word(8'hB0, 1'b0);
	endtask

	task automatic test_bad_continuation();
		send_word(8'hE4, 1'b0);
		send_word(8'hB8, 1'b0);
		send_word(8'h41, 1'b0);
	endtask

	task automatic test_end_of_stream();
		send_word(8'hE4, 1'b0);
		send_word(8'h80, 1'b1);
		send_word(8'h80, 1'b0);
	endtask

	task automatic test_fixup_off_hold();
		send_word(8'hE4, 1'b0);
		set_fixup(1'b0);
		send_word(8'h41, 1'b0);
		set_fixup(1'b1);
	endtask

	function automatic logic [7:0] cont_byte();
		return {2'b10, 6'($urandom_range(63))};
	endfunction

	task automatic send_random_run();
		int unsigned kind;
		logic [7:0]  lead;
		logic [7:0]  b;
		kind = $urandom_range(99);
		if (kind < 25) begin
			send_word(8'($urandom_range(8'h20, 8'h7F)), $urandom_range(29) == 0);
		end else if (kind < 42) begin
			send_word(8'($urandom_range(Lead2Min, 8'hDF)), 1'b0);
			send_word(cont_byte(), $urandom_range(29) == 0);
		end else if (kind < 68) begin
			case ($urandom_range(3))
				0: lead = 8'hED;
				1: lead = 8'hEF;
				2: lead = Lead3Min;
				default: lead = 8'($urandom_range(Lead3Min, 8'hEF));
			endcase
			send_word(lead, 1'b0);
			if (lead == 8'hEF && $urandom_range(1)) begin
				send_word(8'hBF, $urandom_range(29) == 0);
				send_word({4'hB, 4'($urandom_range(15))}, $urandom_range(29) == 0);
			end else begin
				send_word(cont_byte(), $urandom_range(29) == 0);
				send_word(cont_byte(), $urandom_range(29) == 0);
			end
		end else if (kind < 78) begin
			lead = 8'($urandom_range(Lead2Min, 8'hEF));
			send_word(lead, 1'b0);
			if (lead >= Lead3Min && $urandom_range(1))
				send_word(cont_byte(), 1'b0);
			do b = 8'($urandom_range(255)); while (b[7:6] == 2'b10);
			send_word(b, $urandom_range(29) == 0);
		end else if (kind < 86) begin
			send_word(8'($urandom_range(8'h1F)), $urandom_range(29) == 0);
		end else begin
			send_word(8'($urandom_range(255)), $urandom_range(9) == 0);
		end
	endtask

	task automatic test_random_traffic();
		int target;
		for (int ph = 0; ph < 8; ph++) begin
			set_fixup(ph % 3 != 2);
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 71; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 71; end
				default: begin send_idle_pct = 26; stall_pct = 26; end
			endcase
			target = words_sent + 42;
			while (words_sent < target)
				send_random_run();
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = 1'b0;
		in_valid       = 1'b0;
		in_word        = '0;
		fixup_on       = 1'b0;
		held_cnt       = 2'd0;
		send_idle_pct  = 0;
		stall_pct      = 0;
		errors         = 0;
		words_sent     = 0;
		words_checked  = 0;
		spaces_checked = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_fixup(1'b1);
		test_single_bytes();
		test_multibyte_codes();
		test_bad_continuation();
		test_end_of_stream();
		test_fixup_off_hold();
		test_random_traffic();

		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (expected_words.size() != 0)
			errors++;
		$display("Sent %0d input bytes, checked %0d output words, %0d of them spaces.",
			words_sent, words_checked, spaces_checked);
		$display("Fixup on and off, held sequences aborted, dropped at end of stream, mixed stalls.");
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", errors);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
